@@ design/pitt_pkg.sv @@
// Shared types and constants for the point-in-tetrahedron test core.
// No dependencies.
`default_nettype none
package pitt_pkg;

	localparam int DET_STAGES = 4;
	localparam int ADDR_W     = 6;
	localparam int MARGIN_W   = 8;

	typedef enum logic [2:0] {
		REG_CORNER_A  = 3'd0,
		REG_CORNER_B  = 3'd1,
		REG_CORNER_C  = 3'd2,
		REG_CORNER_D  = 3'd3,
		REG_MARGIN    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic vld;
		logic in_tet;
		logic degen;
	} side_t;

endpackage
`default_nettype wire

@@ design/pitt_det.sv @@
// Pipelined 3x3 determinant of three signed vectors, four register stages.
// Stage count matches pitt_pkg::DET_STAGES.
`default_nettype none
module pitt_det #(
	parameter int DIFW = 21
) (
	input  wire logic                         clk,
	input  wire logic signed [DIFW-1:0]       u [3],
	input  wire logic signed [DIFW-1:0]       v [3],
	input  wire logic signed [DIFW-1:0]       w [3],
	output logic signed [2*DIFW+DIFW+2:0]     det
);
	localparam int PW   = 2*DIFW;
	localparam int MINW = PW + 1;
	localparam int TW   = DIFW + MINW;
	localparam int DETW = TW + 2;

	logic signed [PW-1:0]   mp_s1 [3];
	logic signed [PW-1:0]   mn_s1 [3];
	logic signed [DIFW-1:0] u_s1  [3];
	logic signed [MINW-1:0] mi_s2 [3];
	logic signed [DIFW-1:0] u_s2  [3];
	logic signed [TW-1:0]   t_s3  [3];
	logic signed [DETW-1:0] det_s4;

	always_ff @(posedge clk) begin
		mp_s1[0] <= v[1] * w[2];
		mn_s1[0] <= v[2] * w[1];
		mp_s1[1] <= v[0] * w[2];
		mn_s1[1] <= v[2] * w[0];
		mp_s1[2] <= v[0] * w[1];
		mn_s1[2] <= v[1] * w[0];
		u_s1 <= u;
		for (int k = 0; k < 3; k++) begin
			mi_s2[k] <= MINW'(mp_s1[k]) - MINW'(mn_s1[k]);
			t_s3[k]  <= u_s2[k] * mi_s2[k];
		end
		u_s2 <= u_s1;
		det_s4 <= DETW'(t_s3[0]) - DETW'(t_s3[1]) + DETW'(t_s3[2]);
	end

	assign det = det_s4;

endmodule
`default_nettype wire

@@ design/pitt_div.sv @@
// Restoring divider, one quotient bit per register stage, fixed point numerator.
// Gives floor((mag << (FRAC_BITS+1)) / den), QB bits, top bit flags overflow.
`default_nettype none
module pitt_div #(
	parameter int DW        = 66,
	parameter int FRAC_BITS = 16,
	parameter int QB        = 20
) (
	input  wire logic          clk,
	input  wire logic [DW-1:0] mag,
	input  wire logic [DW-1:0] den,
	input  wire logic          neg,
	output logic [QB-1:0]      quo,
	output logic               neg_out
);
	localparam int RW = DW + FRAC_BITS + QB + 1;

	logic [RW-1:0] rem_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic          neg_s [QB+1];

	assign rem_s[0] = RW'(mag) << (FRAC_BITS + 1);
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign neg_s[0] = neg;

	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int K = QB - 1 - j;
		logic [RW-1:0] dsh;
		logic          ge;
		assign dsh = RW'(den_s[j]) << K;
		assign ge  = rem_s[j] >= dsh;
		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? rem_s[j] - dsh : rem_s[j];
			quo_s[j+1] <= quo_s[j] | (QB'(ge) << K);
			den_s[j+1] <= den_s[j];
			neg_s[j+1] <= neg_s[j];
		end
	end

	assign quo     = quo_s[QB];
	assign neg_out = neg_s[QB];

endmodule
`default_nettype wire

@@ design/point_in_tetrahedron_test_core.sv @@
// Point-in-tetrahedron test: top level, APB register file and result stage.
// Uses pitt_pkg, pitt_det and pitt_div.
//
// One query point is taken every cycle (busy stays low) and its result
// appears on done after passing these register stages, in order:
// four stages for the determinants, one for sign and bounds, WEIGHT_WIDTH+2
// for the bit-per-stage divider and one for rounding and saturation. The
// receiver cannot stall; every result is shown for one cycle only. Corner
// and margin registers sit at byte address 8*i on the 64-bit APB port and
// are to be written only while no request is in flight.
`default_nettype none
module point_in_tetrahedron_test_core #(
	parameter int COORD_WIDTH  = 20,
	parameter int FRAC_BITS    = 16,
	parameter int WEIGHT_WIDTH = 18
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [pitt_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [63:0]                    pwdata,
	output logic [63:0]                         prdata,
	output logic                                pready,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic signed [COORD_WIDTH-1:0]  point_x,
	input  wire logic signed [COORD_WIDTH-1:0]  point_y,
	input  wire logic signed [COORD_WIDTH-1:0]  point_z,
	output logic                                done,
	output logic                                inside_res,
	output logic signed [WEIGHT_WIDTH-1:0]      bary_0,
	output logic signed [WEIGHT_WIDTH-1:0]      bary_1,
	output logic signed [WEIGHT_WIDTH-1:0]      bary_2,
	output logic signed [WEIGHT_WIDTH-1:0]      bary_3,
	output logic                                degenerate
);
	localparam int CW     = COORD_WIDTH;
	localparam int CORNW  = 3 * CW;
	localparam int DIFW   = CW + 1;
	localparam int DETW   = 3 * DIFW + 3;
	localparam int MW     = pitt_pkg::MARGIN_W;
	localparam int DMW    = DETW + MW;
	localparam int CMPW   = DETW + FRAC_BITS + MW + 2;
	localparam int QB     = WEIGHT_WIDTH + 2;
	localparam int DS     = pitt_pkg::DET_STAGES;
	localparam logic [WEIGHT_WIDTH:0] POSMAX = (WEIGHT_WIDTH+1)'(2**(WEIGHT_WIDTH-1) - 1);
	localparam logic [WEIGHT_WIDTH:0] NEGMAX = (WEIGHT_WIDTH+1)'(2**(WEIGHT_WIDTH-1));

	// registers
	logic [CORNW-1:0] corner_q [4];
	logic [MW-1:0]    margin_q;
	logic [2:0]       widx;

	assign widx   = paddr[5:3];
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) corner_q[i] <= '0;
			margin_q <= MW'(1);
		end else if (psel && penable && pwrite) begin
			case (widx)
				pitt_pkg::REG_CORNER_A: corner_q[0] <= pwdata[CORNW-1:0];
				pitt_pkg::REG_CORNER_B: corner_q[1] <= pwdata[CORNW-1:0];
				pitt_pkg::REG_CORNER_C: corner_q[2] <= pwdata[CORNW-1:0];
				pitt_pkg::REG_CORNER_D: corner_q[3] <= pwdata[CORNW-1:0];
				pitt_pkg::REG_MARGIN:   margin_q    <= pwdata[MW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			pitt_pkg::REG_CORNER_A: prdata = 64'(corner_q[0]);
			pitt_pkg::REG_CORNER_B: prdata = 64'(corner_q[1]);
			pitt_pkg::REG_CORNER_C: prdata = 64'(corner_q[2]);
			pitt_pkg::REG_CORNER_D: prdata = 64'(corner_q[3]);
			pitt_pkg::REG_MARGIN:   prdata = 64'(margin_q);
			default:                prdata = '0;
		endcase
	end

	// edge vectors
	logic signed [CW-1:0]   crd [4][3];
	logic signed [CW-1:0]   pt  [3];
	logic signed [DIFW-1:0] ba [3], ca [3], da [3], pa [3], bp [3], cp [3], dp [3];

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	always_comb begin
		for (int i = 0; i < 4; i++)
			for (int k = 0; k < 3; k++)
				crd[i][k] = $signed(corner_q[i][k*CW +: CW]);
		for (int k = 0; k < 3; k++) begin
			ba[k] = DIFW'(crd[1][k]) - DIFW'(crd[0][k]);
			ca[k] = DIFW'(crd[2][k]) - DIFW'(crd[0][k]);
			da[k] = DIFW'(crd[3][k]) - DIFW'(crd[0][k]);
			pa[k] = DIFW'(pt[k]) - DIFW'(crd[0][k]);
			bp[k] = DIFW'(crd[1][k]) - DIFW'(pt[k]);
			cp[k] = DIFW'(crd[2][k]) - DIFW'(pt[k]);
			dp[k] = DIFW'(crd[3][k]) - DIFW'(pt[k]);
		end
	end

	logic signed [DETW-1:0] vol;
	logic signed [DETW-1:0] num [4];

	pitt_det #(.DIFW(DIFW)) u_det_v (.clk, .u(ba), .v(ca), .w(da), .det(vol));
	pitt_det #(.DIFW(DIFW)) u_det_0 (.clk, .u(bp), .v(cp), .w(dp), .det(num[0]));
	pitt_det #(.DIFW(DIFW)) u_det_1 (.clk, .u(pa), .v(ca), .w(da), .det(num[1]));
	pitt_det #(.DIFW(DIFW)) u_det_2 (.clk, .u(ba), .v(pa), .w(da), .det(num[2]));
	pitt_det #(.DIFW(DIFW)) u_det_3 (.clk, .u(ba), .v(ca), .w(pa), .det(num[3]));

	logic [DS-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else         vld_q <= {vld_q[DS-2:0], start && !busy};
	end

	// sign, magnitude and bounds
	logic signed [DETW-1:0] t_s5 [4];
	logic [DETW-1:0]        mag_s5 [4];
	logic                   neg_s5 [4];
	logic [DETW-1:0]        dmag_s5;
	logic [DMW-1:0]         dm_s5;
	logic                   degen_s5;
	logic                   vld_s5;
	logic signed [DETW-1:0] tn [4];
	logic [DETW-1:0]        dmag;

	always_comb begin
		dmag = vol[DETW-1] ? DETW'(-vol) : DETW'(vol);
		for (int i = 0; i < 4; i++)
			tn[i] = vol[DETW-1] ? -num[i] : num[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else         vld_s5 <= vld_q[DS-1];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			t_s5[i]   <= tn[i];
			neg_s5[i] <= tn[i][DETW-1];
			mag_s5[i] <= tn[i][DETW-1] ? DETW'(-tn[i]) : DETW'(tn[i]);
		end
		dmag_s5  <= dmag;
		dm_s5    <= dmag * margin_q;
		degen_s5 <= vol == '0;
	end

	logic signed [CMPW-1:0] lowb, highb;
	logic                   inside_c;

	always_comb begin
		lowb     = -$signed(CMPW'(dm_s5));
		highb    = $signed((CMPW'(dmag_s5) << FRAC_BITS) + CMPW'(dm_s5));
		inside_c = !degen_s5;
		for (int i = 0; i < 4; i++) begin
			if (!(($signed(CMPW'(t_s5[i])) <<< FRAC_BITS) > lowb &&
			      ($signed(CMPW'(t_s5[i])) <<< FRAC_BITS) < highb))
				inside_c = 1'b0;
		end
	end

	logic [QB-1:0] quo   [4];
	logic          neg_o [4];

	for (genvar i = 0; i < 4; i++) begin : g_div
		pitt_div #(.DW(DETW), .FRAC_BITS(FRAC_BITS), .QB(QB)) u_div (
			.clk, .mag(mag_s5[i]), .den(dmag_s5), .neg(neg_s5[i]),
			.quo(quo[i]), .neg_out(neg_o[i])
		);
	end

	pitt_pkg::side_t side_s [QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < QB; j++) side_s[j] <= '0;
		end else begin
			side_s[0] <= '{vld: vld_s5, in_tet: inside_c, degen: degen_s5};
			for (int j = 1; j < QB; j++) side_s[j] <= side_s[j-1];
		end
	end

	// rounding and saturation
	logic signed [WEIGHT_WIDTH-1:0] wt [4];
	logic [WEIGHT_WIDTH:0]          qr [4];
	logic [WEIGHT_WIDTH:0]          qs [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qr[i] = (WEIGHT_WIDTH+1)'(({1'b0, quo[i][WEIGHT_WIDTH:0]} +
				(WEIGHT_WIDTH+2)'(1)) >> 1);
			if (neg_o[i])
				qs[i] = (quo[i][QB-1] || qr[i] > NEGMAX) ? NEGMAX : qr[i];
			else
				qs[i] = (quo[i][QB-1] || qr[i] > POSMAX) ? POSMAX : qr[i];
			wt[i] = neg_o[i] ? WEIGHT_WIDTH'(-qs[i]) : WEIGHT_WIDTH'(qs[i]);
			if (side_s[QB-1].degen) wt[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= side_s[QB-1].vld;
	end

	always_ff @(posedge clk) begin
		inside_res <= side_s[QB-1].in_tet;
		degenerate <= side_s[QB-1].degen;
		bary_0     <= wt[0];
		bary_1     <= wt[1];
		bary_2     <= wt[2];
		bary_3     <= wt[3];
	end

endmodule
`default_nettype wire

@@ design/pitt_chk.sv @@
// Port-level checker for the point-in-tetrahedron test core, with its bind.
// Uses pitt_pkg for the determinant stage count.
`default_nettype none
module pitt_chk #(
	parameter int WEIGHT_WIDTH = 18
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           start,
	input wire logic                           busy,
	input wire logic                           done,
	input wire logic                           inside_res,
	input wire logic signed [WEIGHT_WIDTH-1:0] bary_0,
	input wire logic signed [WEIGHT_WIDTH-1:0] bary_1,
	input wire logic signed [WEIGHT_WIDTH-1:0] bary_2,
	input wire logic signed [WEIGHT_WIDTH-1:0] bary_3,
	input wire logic                           degenerate
);
	localparam int LAT = pitt_pkg::DET_STAGES + WEIGHT_WIDTH + 4;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("request result missing");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LAT !done)
		else $error("result without request");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> !inside_res && bary_0 == '0 && bary_1 == '0 &&
			bary_2 == '0 && bary_3 == '0)
		else $error("degenerate result not cleared");

	a_inside_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && inside_res |-> bary_0 > -(2 ** pitt_pkg::MARGIN_W))
		else $error("inside with large negative weight");

endmodule

bind point_in_tetrahedron_test_core pitt_chk #(.WEIGHT_WIDTH(WEIGHT_WIDTH)) u_pitt_chk (
	.clk, .arst_n, .start, .busy, .done, .inside_res,
	.bary_0, .bary_1, .bary_2, .bary_3, .degenerate
);
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for point_in_tetrahedron_test_core.
// Depends on pitt_pkg and the core RTL; computes the expected barycentric weights itself.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 20;
	localparam int WW = 18;
	localparam int FB = 16;
	localparam logic signed [CW-1:0] ONE  = 20'sd65536;
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] ZERO = '0;

	typedef logic signed [127:0] wide_t;
	typedef struct {
		logic in_tet;
		logic [WW-1:0] w[4];
		logic degen;
	} weights_t;

	logic clk = 1'b0, arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [pitt_pkg::ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0, prdata;
	logic pready, start = 1'b0, busy, done;
	logic signed [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic inside_res, degenerate;
	logic signed [WW-1:0] bary_0, bary_1, bary_2, bary_3;

	logic [63:0] corner_cfg[4];
	logic [7:0] margin_cfg;
	weights_t weights_due[$];
	int errors = 0, requests = 0, results = 0, degen_seen = 0, inside_seen = 0;
	bit gaps_on = 1'b1;

	point_in_tetrahedron_test_core u_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .point_x(point_x), .point_y(point_y),
		.point_z(point_z), .done(done), .inside_res(inside_res), .bary_0(bary_0),
		.bary_1(bary_1), .bary_2(bary_2), .bary_3(bary_3), .degenerate(degenerate)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic wide_t det3(wide_t u[3], wide_t v[3], wide_t w[3]);
		wide_t m0, m1, m2;
		m0 = v[1] * w[2] - v[2] * w[1];
		m1 = v[0] * w[2] - v[2] * w[0];
		m2 = v[0] * w[1] - v[1] * w[0];
		return u[0] * m0 - u[1] * m1 + u[2] * m2;
	endfunction

	function automatic weights_t predict_weights(logic signed [CW-1:0] x, y, z);
		weights_t r;
		wide_t c[4][3], p[3], ba[3], ca[3], da[3], pa[3], bp[3], cp[3], dp[3];
		wide_t vol, dmag, lowb, highb, t, ts, q, num[4];
		p[0] = x;
		p[1] = y;
		p[2] = z;
		for (int i = 0; i < 4; i++)
			for (int k = 0; k < 3; k++)
				c[i][k] = $signed(corner_cfg[i][CW*k +: CW]);
		for (int k = 0; k < 3; k++) begin
			ba[k] = c[1][k] - c[0][k];
			ca[k] = c[2][k] - c[0][k];
			da[k] = c[3][k] - c[0][k];
			pa[k] = p[k] - c[0][k];
			bp[k] = c[1][k] - p[k];
			cp[k] = c[2][k] - p[k];
			dp[k] = c[3][k] - p[k];
		end
		vol = det3(ba, ca, da);
		r.in_tet = 1'b0;
		r.degen = 1'b0;
		for (int i = 0; i < 4; i++) r.w[i] = '0;
		if (vol == 0) begin
			r.degen = 1'b1;
			return r;
		end
		num[0] = det3(bp, cp, dp);
		num[1] = det3(pa, ca, da);
		num[2] = det3(ba, pa, da);
		num[3] = det3(ba, ca, pa);
		dmag = vol < 0 ? -vol : vol;
		lowb = -(dmag * wide_t'(margin_cfg));
		highb = dmag * (wide_t'(1 << FB) + wide_t'(margin_cfg));
		r.in_tet = 1'b1;
		for (int i = 0; i < 4; i++) begin
			t = vol < 0 ? -num[i] : num[i];
			ts = t <<< FB;
			if (!(ts > lowb && ts < highb)) r.in_tet = 1'b0;
			q = ((ts < 0 ? -ts : ts) * 2 + dmag) / (dmag * 2);
			if (t < 0) begin
				if (q > (wide_t'(1) << (WW - 1))) q = wide_t'(1) << (WW - 1);
				r.w[i] = WW'(-q);
			end else begin
				if (q > (wide_t'(1) << (WW - 1)) - 1) q = (wide_t'(1) << (WW - 1)) - 1;
				r.w[i] = WW'(q);
			end
		end
		return r;
	endfunction

	task automatic report(string what, logic [WW-1:0] got, logic [WW-1:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// request capture and result check
	always @(posedge clk) begin
		weights_t e;
		logic [WW-1:0] got[4];
		if (arst_n && done) begin
			results++;
			got[0] = bary_0;
			got[1] = bary_1;
			got[2] = bary_2;
			got[3] = bary_3;
			if (weights_due.size() == 0) begin
				report("unexpected result", '0, '0);
			end else begin
				e = weights_due.pop_front();
				if (inside_res !== e.in_tet)
					report("inside_res", WW'(inside_res), WW'(e.in_tet));
				if (degenerate !== e.degen)
					report("degenerate", WW'(degenerate), WW'(e.degen));
				for (int i = 0; i < 4; i++)
					if (got[i] !== e.w[i]) report($sformatf("bary_%0d", i), got[i], e.w[i]);
				if (e.degen) degen_seen++;
				if (e.in_tet) inside_seen++;
			end
		end
		if (arst_n && start && !busy) begin
			requests++;
			weights_due = {weights_due, predict_weights(point_x, point_y, point_z)};
		end
	end

	task automatic reg_write(pitt_pkg::reg_idx_t idx, logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= pitt_pkg::ADDR_W'({idx, 3'b000});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == pitt_pkg::REG_MARGIN) margin_cfg = value[7:0];
		else corner_cfg[idx[1:0]] = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		int n;
		n = 0;
		@(negedge clk);
		start <= 1'b0;
		while (weights_due.size() != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		repeat (WW + 12) @(posedge clk);
	endtask

	task automatic send_point(logic signed [CW-1:0] x, y, z);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic [63:0] pack3(logic signed [CW-1:0] x, y, z);
		return {4'h0, z, y, x};
	endfunction

	task automatic load_tetra(logic [63:0] a, b, c, d, logic [7:0] m);
		drain();
		reg_write(pitt_pkg::REG_CORNER_A, a);
		reg_write(pitt_pkg::REG_CORNER_B, b);
		reg_write(pitt_pkg::REG_CORNER_C, c);
		reg_write(pitt_pkg::REG_CORNER_D, d);
		reg_write(pitt_pkg::REG_MARGIN, {56'd0, m});
	endtask

	task automatic test_reset_degenerate();
		send_point(ZERO, ZERO, ZERO);
		send_point(ONE, -ONE, 20'sd12345);
	endtask

	task automatic test_unit_tetra();
		load_tetra(64'd0, pack3(ONE, ZERO, ZERO), pack3(ZERO, ONE, ZERO),
			pack3(ZERO, ZERO, ONE), 8'd0);
		send_point(ONE >>> 2, ONE >>> 2, ONE >>> 2);
		send_point(ZERO, ZERO, ZERO);
		send_point(ONE, ZERO, ZERO);
		send_point(ONE >>> 1, ONE >>> 1, ZERO);
		send_point(-20'sd1, 20'sd100, 20'sd100);
		send_point(CMIN, CMIN, CMIN);
		send_point(CMAX, CMAX, CMAX);
		send_point(CMIN, CMAX, ZERO);
		drain();
		reg_write(pitt_pkg::REG_MARGIN, 64'd255);
		send_point(ONE >>> 1, ONE >>> 1, ZERO);
		send_point(-20'sd200, 20'sd100, 20'sd100);
		send_point(-20'sd255, 20'sd100, 20'sd100);
		// swapped corners: negative volume
		load_tetra(64'd0, pack3(ZERO, ONE, ZERO), pack3(ONE, ZERO, ZERO),
			pack3(ZERO, ZERO, ONE), 8'd1);
		send_point(ONE >>> 2, ONE >>> 3, ONE >>> 1);
		send_point(ONE >>> 1, ONE >>> 1, ZERO);
		// extreme corners
		load_tetra(pack3(CMIN, CMIN, CMIN), pack3(CMAX, CMIN, CMIN),
			pack3(CMIN, CMAX, CMIN),
			64'hf000_0000_0000_0000 | pack3(CMIN, CMIN, CMAX), 8'd255);
		send_point(ZERO, ZERO, ZERO);
		send_point(CMAX, CMAX, CMAX);
		send_point(CMIN, CMIN, CMIN);
	endtask

	function automatic logic signed [CW-1:0] rnd_coord(int span);
		return CW'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic random_phase(int items, int span, bit flat, logic [7:0] m);
		logic [63:0] cr[4];
		logic signed [CW-1:0] q[3];
		int k;
		for (int i = 0; i < 4; i++)
			cr[i] = span == 0 ? {$urandom(), $urandom()}
				: {4'($urandom_range(0, 15)), 60'(pack3(rnd_coord(span),
				rnd_coord(span), rnd_coord(span)))};
		if (flat) cr[3] = cr[$urandom_range(0, 2)];
		load_tetra(cr[0], cr[1], cr[2], cr[3], m);
		for (int n = 0; n < items; n++) begin
			k = $urandom_range(0, 3);
			for (int a = 0; a < 3; a++) begin
				// most points near the corner centroid so that both outcomes occur
				if (k == 0 || span == 0)
					q[a] = CW'($urandom());
				else
					q[a] = CW'(($signed(cr[0][CW*a +: CW]) + $signed(cr[1][CW*a +: CW])
						+ $signed(cr[2][CW*a +: CW]) + $signed(cr[3][CW*a +: CW])) / 4
						+ rnd_coord(span / 2 + 1));
			end
			send_point(q[0], q[1], q[2]);
		end
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 10; ph++)
			random_phase(80, ph % 3 == 0 ? 0 : ($urandom_range(1, 8) << ($urandom_range(4, 15))),
				ph == 4, ph == 1 ? 8'd0 : ph == 2 ? 8'd255 : 8'($urandom()));
		// sender holds until the pipe is empty
		drain();
		gaps_on = 1'b0;
		random_phase(100, 1 << 14, 1'b0, 8'd3);
	endtask

	initial begin
		corner_cfg = '{default: 64'd0};
		margin_cfg = 8'd1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_degenerate();
		test_unit_tetra();
		test_random();
		drain();
		$display("%0d points sent, %0d results checked (%0d inside, %0d degenerate)",
			requests, results, inside_seen, degen_seen);
		$display("covered unit, swapped, extreme, flat and random tetrahedra, margins 0 to 255");
		if (weights_due.size() != 0) errors++;
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

@@ point_in_tetrahedron_test_core.f @@
design/pitt_pkg.sv
design/pitt_det.sv
design/pitt_div.sv
design/point_in_tetrahedron_test_core.sv
design/pitt_chk.sv
tb/tb.sv
